>>> src/assert_macros.svh
// Assertion helpers shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition on one edge implies another on the next edge
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> src/hpic_pkg.sv
package hpic_pkg;

    localparam int TEMP_W   = 13;
    localparam int LIMIT_W  = 27;
    localparam int OFF_W    = 9;
    localparam int WIN_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_PINS = 4;

    localparam int PIN_PRESSURE  = 0;
    localparam int PIN_HEAT      = 1;
    localparam int PIN_PUMP_LOW  = 2;
    localparam int PIN_PUMP_HIGH = 3;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_TEMP   = 2'd1;
    localparam logic [1:0] OP_TARGET = 2'd2;

    localparam logic signed [TEMP_W-1:0] T_DEFAULT     = 13'sd1040;
    localparam logic signed [TEMP_W-1:0] T_ERROR       = 13'sd3200;
    localparam logic signed [TEMP_W-1:0] T_VALID_ABOVE = -13'sd1600;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PUMP_IDLE_LIMIT = 3'd0,
        REG_PUMP_MIN_RUN    = 3'd1,
        REG_PRE_POST_RUN    = 3'd2,
        REG_HYSTERESIS      = 3'd3,
        REG_TARGET_UPPER    = 3'd4,
        REG_TARGET_LOWER    = 3'd5,
        REG_DEBOUNCE_WINDOW = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] pump_idle_limit_ms;
        logic [LIMIT_W-1:0] pump_min_run_ms;
        logic [LIMIT_W-1:0] pre_post_run_ms;
        logic [OFF_W-1:0]   hysteresis_offset;
        logic [TEMP_W-1:0]  target_upper_limit;
        logic [TEMP_W-1:0]  target_lower_limit;
        logic [WIN_W-1:0]   debounce_window_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]          op;
        logic [NUM_PINS-1:0] raw_pins;
        logic [TEMP_W-1:0]   temp_reading;
        logic [TEMP_W-1:0]   target_value;
    } in_item_t;

    // Packed from the top bit down, so heater_drive lands in bit 0
    typedef struct packed {
        logic [TEMP_W-1:0] active_target;
        logic [TEMP_W-1:0] measured_temp;
        logic              pump_high_seen;
        logic              pump_low_seen;
        logic              heat_seen;
        logic              pressure_ok;
        logic              pump_drive;
        logic              heater_drive;
    } result_t;

endpackage

>>> src/heater_pump_interlock_controller_unit.sv
// Channel  | Direction | Signals                              | Carries
// s_axis   | in        | s_tvalid s_tready s_tdata s_tuser    | tick, temperature or target item
// m_axis   | out       | m_tvalid m_tready m_tdata            | relay and status result
// cfg      | in        | cfg_valid cfg_ready cfg_index cfg_data | register write
//
// Each item passes through the input register, then its result sits in the output
// register, which drives m_tvalid; one item per cycle is sustained while m_tready is high.
// Throughput is set by the single update of the controller state as an item leaves the
// input register. Reset (rst_n low, asynchronous) empties both registers and loads
// the default settings. A stalled output holds its result; the input register keeps
// taking items while the output register is free or being drained in the same cycle.
`include "assert_macros.svh"

module heater_pump_interlock_controller_unit #(
    parameter int TIME_BITS = 27,
    parameter int AGE_BITS  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [0] pressure_pin, [1] heat_sense_pin, [2] pump_low_sense_pin,
    // [3] pump_high_sense_pin, [16:4] temp_reading, [29:17] target_value, [31:30] zero
    input  logic [31:0]                    s_tdata,
    // [1:0] op
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] heater_drive, [1] pump_drive, [2] pressure_ok, [3] heat_seen,
    // [4] pump_low_seen, [5] pump_high_seen, [18:6] measured_temp, [31:19] active_target
    output logic [31:0]                    m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hpic_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hpic_pkg::LIMIT_W-1:0]   cfg_data
);
    import hpic_pkg::*;

    logic     in_valid_reg, in_valid_next;
    in_item_t in_item_reg, in_item_next;
    logic     out_valid_reg, out_valid_next;
    result_t  out_data_reg, out_data_next;

    logic                advance;
    logic                tick;
    cfg_t                cfg;
    result_t             result_next;
    logic [NUM_PINS-1:0] pins_seen;
    logic [NUM_PINS-1:0] pin_invert;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign tick     = advance && (in_item_reg.op == OP_TICK);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // the pressure switch pulls low when pressure is present
    assign pin_invert = NUM_PINS'(1) << PIN_PRESSURE;

    hpic_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    for (genvar i = 0; i < NUM_PINS; i++)
    begin : g_pin
        hpic_debounce #(
            .AGE_BITS (AGE_BITS)
        ) u_debounce (
            .clk           (clk),
            .rst_n         (rst_n),
            .tick          (tick),
            .raw           (in_item_reg.raw_pins[i]),
            .invert        (pin_invert[i]),
            .window        (cfg.debounce_window_ms),
            .accepted_next (pins_seen[i])
        );
    end

    hpic_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .item        (in_item_reg),
        .cfg         (cfg),
        .pins_seen   (pins_seen),
        .result_next (result_next)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next             = 1'b1;
            in_item_next.op           = s_tuser;
            in_item_next.raw_pins     = s_tdata[3:0];
            in_item_next.temp_reading = s_tdata[16:4];
            in_item_next.target_value = s_tdata[29:17];
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result_next;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        in_item_reg  <= in_item_next;
        out_data_reg <= out_data_next;
    end

    `ASSERT_CLK(a_stall_means_both_full, clk, rst_n,
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready),
        "input stalled with room downstream")
    `ASSERT_NEXT(a_advance_gives_result, clk, rst_n, advance,
        out_valid_reg, "item left the input register without a result")

endmodule

>>> src/hpic_cfg_regs.sv
module hpic_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hpic_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hpic_pkg::LIMIT_W-1:0]   cfg_data,
    output hpic_pkg::cfg_t                 cfg
);
    import hpic_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_PUMP_IDLE_LIMIT: cfg_next.pump_idle_limit_ms = cfg_data;
                REG_PUMP_MIN_RUN:    cfg_next.pump_min_run_ms    = cfg_data;
                REG_PRE_POST_RUN:    cfg_next.pre_post_run_ms    = cfg_data;
                REG_HYSTERESIS:      cfg_next.hysteresis_offset  = cfg_data[OFF_W-1:0];
                REG_TARGET_UPPER:    cfg_next.target_upper_limit = cfg_data[TEMP_W-1:0];
                REG_TARGET_LOWER:    cfg_next.target_lower_limit = cfg_data[TEMP_W-1:0];
                REG_DEBOUNCE_WINDOW: cfg_next.debounce_window_ms = cfg_data[WIN_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pump_idle_limit_ms <= 27'd3600000;
            cfg_reg.pump_min_run_ms    <= 27'd60000;
            cfg_reg.pre_post_run_ms    <= 27'd30000;
            cfg_reg.hysteresis_offset  <= 9'd16;
            cfg_reg.target_upper_limit <= 13'd1664;
            cfg_reg.target_lower_limit <= 13'd800;
            cfg_reg.debounce_window_ms <= 16'd500;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> src/hpic_debounce.sv
module hpic_debounce #(
    parameter int AGE_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       tick,
    input  logic                       raw,
    input  logic                       invert,
    input  logic [hpic_pkg::WIN_W-1:0] window,
    output logic                       accepted_next
);
    import hpic_pkg::*;

    localparam int CMP_W = (AGE_BITS > WIN_W) ? AGE_BITS : WIN_W;

    logic                prev_reg;
    logic                prev_next;
    logic [AGE_BITS-1:0] age_reg;
    logic [AGE_BITS-1:0] age_next;
    logic                accepted_reg;

    always_comb
    begin
        prev_next     = prev_reg;
        age_next      = age_reg;
        accepted_next = accepted_reg;
        if (tick)
        begin
            if (raw != prev_reg)
            begin
                prev_next = raw;
                age_next  = '0;
            end
            else if (age_reg != {AGE_BITS{1'b1}})
            begin
                age_next = age_reg + 1'b1;
            end
            // follow the pin once it has been stable past the window
            if (CMP_W'(age_next) > CMP_W'(window))
            begin
                accepted_next = raw ^ invert;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg     <= 1'b0;
            age_reg      <= '0;
            accepted_reg <= 1'b0;
        end
        else
        begin
            prev_reg     <= prev_next;
            age_reg      <= age_next;
            accepted_reg <= accepted_next;
        end
    end

endmodule

>>> src/hpic_core.sv
`include "assert_macros.svh"

module hpic_core #(
    parameter int TIME_BITS = 27
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  hpic_pkg::in_item_t            item,
    input  hpic_pkg::cfg_t                cfg,
    input  logic [hpic_pkg::NUM_PINS-1:0] pins_seen,
    output hpic_pkg::result_t             result_next
);
    import hpic_pkg::*;

    localparam int CMP_W = (TIME_BITS > LIMIT_W) ? TIME_BITS : LIMIT_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    logic [TIME_BITS-1:0] since_pressure_reg, since_pressure_next;
    logic [TIME_BITS-1:0] since_pump_start_reg, since_pump_start_next;
    logic [TIME_BITS-1:0] since_heat_off_reg, since_heat_off_next;
    logic                 heater_on_reg, heater_on_next;
    logic                 pump_on_reg, pump_on_next;
    logic                 start_request_reg, start_request_next;
    logic                 pressure_seen_reg;
    logic [TEMP_W-1:0]    current_temp_reg, current_temp_next;
    logic [TEMP_W-1:0]    target_temp_reg, target_temp_next;

    logic signed [TEMP_W:0] cur_ext;
    logic signed [TEMP_W:0] band_lo;
    logic signed [TEMP_W:0] band_hi;
    logic                   pressure;

    assign pressure = pins_seen[PIN_PRESSURE];
    assign cur_ext  = $signed({current_temp_reg[TEMP_W-1], current_temp_reg});
    assign band_lo  = $signed({target_temp_reg[TEMP_W-1], target_temp_reg})
                    - $signed({5'b0, cfg.hysteresis_offset});
    assign band_hi  = $signed({target_temp_reg[TEMP_W-1], target_temp_reg})
                    + $signed({5'b0, cfg.hysteresis_offset});

    always_comb
    begin
        since_pressure_next   = since_pressure_reg;
        since_pump_start_next = since_pump_start_reg;
        since_heat_off_next   = since_heat_off_reg;
        heater_on_next        = heater_on_reg;
        pump_on_next          = pump_on_reg;
        start_request_next    = start_request_reg;
        current_temp_next     = current_temp_reg;
        target_temp_next      = target_temp_reg;
        if (advance)
        begin
            case (item.op)
                OP_TICK:
                begin
                    // saturate rather than wrap
                    if (since_pressure_reg != TIME_MAX)
                        since_pressure_next = since_pressure_reg + 1'b1;
                    if (since_pump_start_reg != TIME_MAX)
                        since_pump_start_next = since_pump_start_reg + 1'b1;
                    if (since_heat_off_reg != TIME_MAX)
                        since_heat_off_next = since_heat_off_reg + 1'b1;
                    if (pressure)
                        since_pressure_next = '0;

                    if (CMP_W'(since_pressure_next) > CMP_W'(cfg.pump_idle_limit_ms)
                        || start_request_reg)
                    begin
                        pump_on_next          = 1'b1;
                        since_pump_start_next = '0;
                        start_request_next    = 1'b0;
                    end

                    if (pump_on_next && !heater_on_reg
                        && CMP_W'(since_pump_start_next) > CMP_W'(cfg.pump_min_run_ms)
                        && CMP_W'(since_heat_off_next) > CMP_W'(cfg.pre_post_run_ms))
                        pump_on_next = 1'b0;

                    if (pressure && cur_ext < band_lo
                        && CMP_W'(since_pump_start_next) > CMP_W'(cfg.pre_post_run_ms))
                        heater_on_next = 1'b1;

                    // drop the heater and restart the post-run timer on a falling edge
                    if (!pressure || cur_ext > band_hi)
                    begin
                        if (heater_on_next)
                            since_heat_off_next = '0;
                        heater_on_next = 1'b0;
                    end
                end
                OP_TEMP:
                begin
                    if ($signed(item.temp_reading) > T_VALID_ABOVE)
                        current_temp_next = item.temp_reading;
                    else
                        current_temp_next = T_ERROR;
                end
                OP_TARGET:
                begin
                    if ($signed(item.target_value) > $signed(cfg.target_upper_limit)
                        || $signed(item.target_value) < $signed(cfg.target_lower_limit))
                        target_temp_next = T_DEFAULT;
                    else
                        target_temp_next = item.target_value;
                    start_request_next = 1'b1;
                end
                default:
                begin
                    start_request_next = start_request_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        result_next.heater_drive   = heater_on_next;
        result_next.pump_drive     = pump_on_next;
        result_next.pressure_ok    = pins_seen[PIN_PRESSURE];
        result_next.heat_seen      = pins_seen[PIN_HEAT];
        result_next.pump_low_seen  = pins_seen[PIN_PUMP_LOW];
        result_next.pump_high_seen = pins_seen[PIN_PUMP_HIGH];
        result_next.measured_temp  = current_temp_next;
        result_next.active_target  = target_temp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            since_pressure_reg   <= '0;
            since_pump_start_reg <= '0;
            since_heat_off_reg   <= '0;
            heater_on_reg        <= 1'b0;
            pump_on_reg          <= 1'b0;
            start_request_reg    <= 1'b0;
            pressure_seen_reg    <= 1'b0;
            current_temp_reg     <= T_ERROR;
            target_temp_reg      <= T_DEFAULT;
        end
        else
        begin
            since_pressure_reg   <= since_pressure_next;
            since_pump_start_reg <= since_pump_start_next;
            since_heat_off_reg   <= since_heat_off_next;
            heater_on_reg        <= heater_on_next;
            pump_on_reg          <= pump_on_next;
            start_request_reg    <= start_request_next;
            pressure_seen_reg    <= pressure;
            current_temp_reg     <= current_temp_next;
            target_temp_reg      <= target_temp_next;
        end
    end

    `ASSERT_CLK(a_heater_needs_pressure, clk, rst_n,
        heater_on_reg |-> pressure_seen_reg, "heater on without debounced pressure")
    `ASSERT_NEXT(a_tick_consumes_start, clk, rst_n, advance && item.op == OP_TICK,
        !start_request_reg, "start request survived a tick")
    `ASSERT_CLK(a_pump_start_clears_timer, clk, rst_n,
        $rose(pump_on_reg) |-> since_pump_start_reg == '0, "pump started without timer restart")

endmodule
